FILE: design/dma_region_translation_table_top_macros.svh
// Assertion macros for the DMA region translation table.
// Used by dma_region_translation_table_top; no other dependencies.
`ifndef DMA_REGION_TRANSLATION_TABLE_TOP_MACROS_SVH
`define DMA_REGION_TRANSLATION_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DRTT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DRTT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRTT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DRTT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: design/drtt_pkg.sv
// Shared types and constants for the DMA region translation table.
// No dependencies.
package drtt_pkg;
    localparam int ENTRIES_DEF   = 64;
    localparam int ADDR_BITS_DEF = 48;
    localparam int LEN_BITS_DEF  = 32;
    localparam int CMD_W         = 3;
    localparam int DIR_W         = 2;
    localparam int STATUS_W      = 3;
    localparam int SLOT_W        = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_FREE      = 3'd1,
        CMD_MAP       = 3'd2,
        CMD_UNMAP     = 3'd3,
        CMD_V2P       = 3'd4,
        CMD_P2V       = 3'd5,
        CMD_QUERY     = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK          = 3'd0,
        STS_FULL        = 3'd1,
        STS_NOT_FOUND   = 3'd2,
        STS_NOT_MAPPING = 3'd3,
        STS_BAD_DIR     = 3'd4,
        STS_ZERO        = 3'd5
    } t_status;

    typedef enum logic [DIR_W-1:0] {
        DIR_BIDIR = 2'd0,
        DIR_TO_DEV = 2'd1,
        DIR_FROM_DEV = 2'd2,
        DIR_NONE = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE,
        S_OUT
    } t_state;
endpackage

FILE: design/drtt_entry_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on nothing; widths come from the top level.
module drtt_entry_ram #(
    parameter int ENTRIES = 64,
    parameter int WIDTH   = 176,
    parameter int IDX_W   = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/dma_region_translation_table_top.sv
// DMA region translation table, top level.
// Depends on drtt_pkg, drtt_entry_ram and the assertion macro header.
//
// Use: one command transfer enters on i_valid/o_stall with cmd and address
// fields; one result transfer leaves on o_valid/i_stall with status,
// result_addr, slot and hit.
// The block handles one command at a time. After a command is taken,
// o_stall stays high until its result has been taken.
// A linear scan reads one entry per cycle from the entry RAM
// through a single compare/subtract unit and stops at the first match.
// A command ends its scan at the slot matched, or after the last slot,
// ENTRIES - 1, on a miss. Bad direction and unused codes skip the scan.
// The block returns to idle after each result transfer before it takes
// the next command.
// The translated address is one add after the scan on the saved offset.
// Reset clears the valid and mapping bits at once; no clearing pass.
// RAM contents are don't-care until written and only read behind a
// valid bit.
// A stalled result holds; the next command waits until it is taken.
`include "dma_region_translation_table_top_macros.svh"
module dma_region_translation_table_top #(
    parameter int ENTRIES   = drtt_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = drtt_pkg::ADDR_BITS_DEF,
    parameter int LEN_BITS  = drtt_pkg::LEN_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [drtt_pkg::CMD_W-1:0]    i_cmd,
    input  logic [ADDR_BITS-1:0]          i_virt_addr,
    input  logic [ADDR_BITS-1:0]          i_phys_addr,
    input  logic [LEN_BITS-1:0]           i_region_size,
    input  logic [ADDR_BITS-1:0]          i_client_addr,
    input  logic [drtt_pkg::DIR_W-1:0]    i_direction,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [drtt_pkg::STATUS_W-1:0] o_status,
    output logic [ADDR_BITS-1:0]          o_result_addr,
    output logic [drtt_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_hit
);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW    = 3 * ADDR_BITS + LEN_BITS;
    localparam int CW    = (ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    drtt_pkg::t_state r_state, n_state;

    // captured command
    drtt_pkg::t_cmd        r_cmd;
    logic [drtt_pkg::DIR_W-1:0] r_dir;
    logic [ADDR_BITS-1:0]  r_va, r_pa, r_ca;
    logic [LEN_BITS-1:0]   r_len;

    logic [ENTRIES-1:0]    r_valid, r_map;
    logic [IDX_W-1:0]      r_rd_idx, r_cmp_idx;
    logic                  r_cmp_vld, r_cmp_ent_v, r_cmp_map;

    // match results
    logic                  r_hit;
    logic [IDX_W-1:0]      r_slot;
    logic                  r_is_map;
    logic [ADDR_BITS-1:0]  r_off, r_other;

    // result register
    logic [drtt_pkg::STATUS_W-1:0] r_o_status;
    logic [ADDR_BITS-1:0]  r_o_addr;
    logic [drtt_pkg::SLOT_W-1:0]   r_o_slot;
    logic                  r_o_hit;

    logic                  in_xfer, scan_en, done_en, skip_scan;
    logic [EW-1:0]         rd_data, wr_data;
    logic                  wr_en;

    assign in_xfer = i_valid && !o_stall;

    // ---------------- entry RAM ----------------
    logic [ADDR_BITS-1:0] e_buf, e_phys, e_client;
    logic [LEN_BITS-1:0]  e_len;

    assign {e_client, e_buf, e_phys, e_len} = rd_data;

    drtt_entry_ram #(
        .ENTRIES (ENTRIES),
        .WIDTH   (EW),
        .IDX_W   (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_slot),
        .i_wdata (wr_data),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    // ---------------- shared compare unit ----------------
    logic [ADDR_BITS-1:0] key, base, other, va_base;
    logic [ADDR_BITS:0]   diff;
    logic                 exact, in_span, match;

    always_comb begin
        va_base = r_cmp_map ? e_client : e_buf;
        key     = (r_cmd == drtt_pkg::CMD_P2V || r_cmd == drtt_pkg::CMD_UNMAP) ? r_pa : r_va;
        case (r_cmd)
            drtt_pkg::CMD_FREE:  base = e_buf;
            drtt_pkg::CMD_UNMAP: base = e_phys;
            drtt_pkg::CMD_P2V:   base = e_phys;
            default:             base = va_base;
        endcase
        other   = (r_cmd == drtt_pkg::CMD_P2V) ? va_base : e_phys;
        diff    = {1'b0, key} - {1'b0, base};
        exact   = (key == base);
        in_span = !diff[ADDR_BITS]
                  && (CW'(diff[ADDR_BITS-1:0]) < CW'(e_len));
        case (r_cmd)
            drtt_pkg::CMD_INSERT, drtt_pkg::CMD_MAP: match = !r_cmp_ent_v;
            drtt_pkg::CMD_FREE, drtt_pkg::CMD_UNMAP: match = r_cmp_ent_v && exact;
            drtt_pkg::CMD_V2P, drtt_pkg::CMD_P2V,
            drtt_pkg::CMD_QUERY:                     match = r_cmp_ent_v && in_span;
            default:                                 match = 1'b0;
        endcase
        match = match && r_cmp_vld;
    end

    always_comb begin
        case (r_cmd)
            drtt_pkg::CMD_INSERT, drtt_pkg::CMD_FREE, drtt_pkg::CMD_UNMAP,
            drtt_pkg::CMD_V2P, drtt_pkg::CMD_P2V, drtt_pkg::CMD_QUERY:
                skip_scan = 1'b0;
            drtt_pkg::CMD_MAP:
                skip_scan = !(r_dir == drtt_pkg::DIR_TO_DEV || r_dir == drtt_pkg::DIR_FROM_DEV);
            default:
                skip_scan = 1'b1;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            drtt_pkg::S_IDLE: begin
                if (in_xfer) n_state = drtt_pkg::S_SCAN;
            end
            drtt_pkg::S_SCAN: begin
                if (skip_scan || match || (r_cmp_vld && r_cmp_idx == LAST_IDX))
                    n_state = drtt_pkg::S_DONE;
            end
            drtt_pkg::S_DONE: n_state = drtt_pkg::S_OUT;
            drtt_pkg::S_OUT: begin
                if (!i_stall) n_state = drtt_pkg::S_IDLE;
            end
            default: n_state = drtt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        scan_en = 1'b0;
        done_en = 1'b0;
        case (r_state)
            drtt_pkg::S_IDLE: o_stall = 1'b0;
            drtt_pkg::S_SCAN: scan_en = 1'b1;
            drtt_pkg::S_DONE: done_en = 1'b1;
            drtt_pkg::S_OUT:  o_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drtt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- result decode ----------------
    logic                          ins_ok, rel_ok;
    logic [drtt_pkg::STATUS_W-1:0] n_status;
    logic [ADDR_BITS-1:0]          n_addr;

    always_comb begin
        ins_ok   = 1'b0;
        rel_ok   = 1'b0;
        n_status = drtt_pkg::STS_NOT_FOUND;
        n_addr   = '0;
        case (r_cmd)
            drtt_pkg::CMD_INSERT, drtt_pkg::CMD_MAP: begin
                if (skip_scan) begin
                    n_status = drtt_pkg::STS_BAD_DIR;
                end else if (!r_hit) begin
                    n_status = drtt_pkg::STS_FULL;
                end else if (r_va == '0 || r_pa == '0) begin
                    n_status = drtt_pkg::STS_ZERO;
                end else begin
                    n_status = drtt_pkg::STS_OK;
                    ins_ok   = 1'b1;
                    if (r_cmd == drtt_pkg::CMD_MAP) n_addr = r_pa;
                end
            end
            drtt_pkg::CMD_FREE: begin
                if (r_hit) begin
                    n_status = drtt_pkg::STS_OK;
                    rel_ok   = 1'b1;
                end
            end
            drtt_pkg::CMD_UNMAP: begin
                if (r_hit && !r_is_map) begin
                    n_status = drtt_pkg::STS_NOT_MAPPING;
                end else if (r_hit) begin
                    n_status = drtt_pkg::STS_OK;
                    rel_ok   = 1'b1;
                end
            end
            drtt_pkg::CMD_V2P, drtt_pkg::CMD_P2V: begin
                if (r_hit) begin
                    n_status = drtt_pkg::STS_OK;
                    n_addr   = r_other + r_off;
                end
            end
            drtt_pkg::CMD_QUERY: begin
                if (r_hit) n_status = drtt_pkg::STS_OK;
            end
            default: ;
        endcase
    end

    assign wr_en   = done_en && ins_ok;
    assign wr_data = {(r_cmd == drtt_pkg::CMD_MAP) ? r_ca : {ADDR_BITS{1'b0}},
                      r_va, r_pa, r_len};

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= drtt_pkg::t_cmd'(i_cmd);
            r_dir <= i_direction;
            r_va  <= i_virt_addr;
            r_pa  <= i_phys_addr;
            r_len <= i_region_size;
            r_ca  <= i_client_addr;
        end
        if (scan_en) begin
            r_cmp_idx   <= r_rd_idx;
            r_cmp_ent_v <= r_valid[r_rd_idx];
            r_cmp_map   <= r_map[r_rd_idx];
        end
        if (scan_en && match && !r_hit) begin
            r_slot   <= r_cmp_idx;
            r_is_map <= r_cmp_map;
            r_off    <= diff[ADDR_BITS-1:0];
            r_other  <= other;
        end
        if (done_en) begin
            r_o_status <= n_status;
            r_o_addr   <= n_addr;
            r_o_hit    <= r_hit;
            r_o_slot   <= r_hit ? drtt_pkg::SLOT_W'(r_slot) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_map     <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end else if (scan_en) begin
                r_rd_idx  <= (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
                r_cmp_vld <= 1'b1;
                if (match) r_hit <= 1'b1;
            end
            if (done_en && ins_ok) begin
                r_valid[r_slot] <= 1'b1;
                r_map[r_slot]   <= (r_cmd == drtt_pkg::CMD_MAP);
            end else if (done_en && rel_ok) begin
                r_valid[r_slot] <= 1'b0;
                r_map[r_slot]   <= 1'b0;
            end
        end
    end

    assign o_status      = r_o_status;
    assign o_result_addr = r_o_addr;
    assign o_slot        = r_o_slot;
    assign o_hit         = r_o_hit;

    // ---------------- assertions ----------------
    `DRTT_ASSERT(a_busy_after_cmd, i_clk, i_rst_n, in_xfer |=> o_stall,
        "command taken while a scan is pending")
    `DRTT_ASSERT(a_one_result, i_clk, i_rst_n, (o_valid && !i_stall) |=> !o_valid,
        "result repeated")
    `DRTT_ASSERT(a_miss_slot_zero, i_clk, i_rst_n, (o_valid && !o_hit) |-> (o_slot == '0),
        "slot reported on a miss")
    `DRTT_ASSERT(a_ok_has_hit, i_clk, i_rst_n,
        (o_valid && o_status == drtt_pkg::STS_OK) |-> o_hit,
        "ok status without a matched entry")
    `DRTT_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !o_valid,
        "result valid right after reset")
endmodule

FILE: tb/sv/tb_dma_region_translation_table_top.sv
// Self-checking bench for the DMA region translation table top level.
// Depends on drtt_pkg and dma_region_translation_table_top.
module tb_dma_region_translation_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 64;
    localparam int AW    = 48;
    localparam int LW    = 32;

    // One command transfer as offered to the block.
    typedef struct {
        drtt_pkg::t_cmd cmd;
        logic [AW-1:0] va;
        logic [AW-1:0] pa;
        logic [LW-1:0] len;
        logic [AW-1:0] ca;
        logic [1:0]    dir;
    } t_req;

    // One result transfer.
    typedef struct {
        logic [2:0]    status;
        logic [AW-1:0] addr;
        logic [5:0]    slot;
        logic          hit;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [drtt_pkg::CMD_W-1:0] i_cmd = '0;
    logic [AW-1:0] i_virt_addr = '0;
    logic [AW-1:0] i_phys_addr = '0;
    logic [LW-1:0] i_region_size = '0;
    logic [AW-1:0] i_client_addr = '0;
    logic [drtt_pkg::DIR_W-1:0] i_direction = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [drtt_pkg::STATUS_W-1:0] o_status;
    logic [AW-1:0] o_result_addr;
    logic [drtt_pkg::SLOT_W-1:0] o_slot;
    logic o_hit;

    dma_region_translation_table_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_virt_addr(i_virt_addr), .i_phys_addr(i_phys_addr),
        .i_region_size(i_region_size), .i_client_addr(i_client_addr),
        .i_direction(i_direction),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_result_addr(o_result_addr),
        .o_slot(o_slot), .o_hit(o_hit)
    );

    // Shadow copy of the region table.
    logic          tbl_valid [NSLOT];
    logic          tbl_map   [NSLOT];
    logic [AW-1:0] tbl_buf   [NSLOT];
    logic [AW-1:0] tbl_phys  [NSLOT];
    logic [LW-1:0] tbl_len   [NSLOT];
    logic [AW-1:0] tbl_client[NSLOT];

    t_req  pending_cmds[$];
    t_resp expected_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;       // receiver long stall, cycles left
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_ok = 0;
    bit feed_done = 0;

    // Base of an entry in the virtual space: client address for mappings.
    function automatic logic [AW-1:0] virt_base(int i);
        return tbl_map[i] ? tbl_client[i] : tbl_buf[i];
    endfunction

    function automatic bit covers(logic [AW-1:0] a, logic [AW-1:0] b, logic [LW-1:0] l);
        logic [AW:0] off;
        off = {1'b0, a} - {1'b0, b};
        return (a >= b) && (off < {17'd0, l});
    endfunction

    // Apply one command to the shadow table and return the result it causes.
    function automatic t_resp table_apply(t_req r);
        t_resp o;
        int s;
        s = -1;
        o.status = drtt_pkg::STS_NOT_FOUND;
        o.addr = '0;
        case (r.cmd)
            drtt_pkg::CMD_INSERT, drtt_pkg::CMD_MAP: begin
                if (r.cmd == drtt_pkg::CMD_MAP && r.dir != drtt_pkg::DIR_TO_DEV
                    && r.dir != drtt_pkg::DIR_FROM_DEV) begin
                    o.status = drtt_pkg::STS_BAD_DIR;
                end else begin
                    for (int i = 0; i < NSLOT; i++)
                        if (s < 0 && !tbl_valid[i]) s = i;
                    if (s < 0) begin
                        o.status = drtt_pkg::STS_FULL;
                    end else if (r.va == '0 || r.pa == '0) begin
                        o.status = drtt_pkg::STS_ZERO;
                    end else begin
                        o.status = drtt_pkg::STS_OK;
                        tbl_valid[s] = 1'b1;
                        tbl_map[s] = (r.cmd == drtt_pkg::CMD_MAP);
                        tbl_buf[s] = r.va;
                        tbl_phys[s] = r.pa;
                        tbl_len[s] = r.len;
                        tbl_client[s] = (r.cmd == drtt_pkg::CMD_MAP) ? r.ca : '0;
                        if (r.cmd == drtt_pkg::CMD_MAP) o.addr = r.pa;
                    end
                end
            end
            drtt_pkg::CMD_FREE: begin
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && tbl_valid[i] && tbl_buf[i] == r.va) s = i;
                if (s >= 0) begin
                    o.status = drtt_pkg::STS_OK;
                    tbl_valid[s] = 1'b0;
                    tbl_map[s] = 1'b0;
                end
            end
            drtt_pkg::CMD_UNMAP: begin
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && tbl_valid[i] && tbl_phys[i] == r.pa) s = i;
                if (s >= 0) begin
                    if (!tbl_map[s]) begin
                        o.status = drtt_pkg::STS_NOT_MAPPING;
                    end else begin
                        o.status = drtt_pkg::STS_OK;
                        tbl_valid[s] = 1'b0;
                        tbl_map[s] = 1'b0;
                    end
                end
            end
            drtt_pkg::CMD_V2P, drtt_pkg::CMD_QUERY: begin
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && tbl_valid[i] && covers(r.va, virt_base(i), tbl_len[i]))
                        s = i;
                if (s >= 0) begin
                    o.status = drtt_pkg::STS_OK;
                    if (r.cmd == drtt_pkg::CMD_V2P)
                        o.addr = tbl_phys[s] + (r.va - virt_base(s));
                end
            end
            drtt_pkg::CMD_P2V: begin
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && tbl_valid[i] && covers(r.pa, tbl_phys[i], tbl_len[i]))
                        s = i;
                if (s >= 0) begin
                    o.status = drtt_pkg::STS_OK;
                    o.addr = virt_base(s) + (r.pa - tbl_phys[s]);
                end
            end
            default: ;
        endcase
        o.hit = (s >= 0);
        o.slot = (s >= 0) ? s[5:0] : 6'd0;
        return o;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Driver: on each edge either advance past an accepted transfer or offer the next.
    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(table_apply(pending_cmds.pop_front()));
                n_sent++;
            end
            if (!(i_valid && o_stall)) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = pending_cmds[0];
                    i_valid <= 1'b1;
                    i_cmd <= r.cmd;
                    i_virt_addr <= r.va;
                    i_phys_addr <= r.pa;
                    i_region_size <= r.len;
                    i_client_addr <= r.ca;
                    i_direction <= r.dir;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer and pick the next stall value.
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: status %0d addr %h slot %0d hit %0d",
                             $time, o_status, o_result_addr, o_slot, o_hit);
                end else begin
                    e = expected_results.pop_front();
                    if (o_status == drtt_pkg::STS_OK) n_ok++;
                    if (o_status !== e.status || o_result_addr !== e.addr ||
                        o_slot !== e.slot || o_hit !== e.hit) begin
                        errors++;
                        $display("%0t: mismatch exp status %0d addr %h slot %0d hit %0d",
                                 $time, e.status, e.addr, e.slot, e.hit);
                        $display("%0t:          got status %0d addr %h slot %0d hit %0d",
                                 $time, o_status, o_result_addr, o_slot, o_hit);
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Address generation: mostly near live regions so lookups hit.
    function automatic logic [AW-1:0] rand_addr();
        logic [AW-1:0] a;
        case ($urandom_range(5))
            0: a = AW'({$urandom, $urandom});
            1: a = 48'h0;
            2: a = 48'hFFFF_FFFF_FFFF - AW'($urandom_range(3));
            default: a = {32'h0, 8'($urandom_range(63)), 8'h0} + 48'h1000;
        endcase
        return a;
    endfunction

    function automatic t_req mk(drtt_pkg::t_cmd c, logic [AW-1:0] va, logic [AW-1:0] pa,
                                logic [LW-1:0] len, logic [AW-1:0] ca, logic [1:0] dir);
        t_req r;
        r.cmd = c; r.va = va; r.pa = pa; r.len = len; r.ca = ca; r.dir = dir;
        return r;
    endfunction

    // Random command biased to well-formed traffic; keys reuse recent inserts.
    task automatic push_random(ref t_req hist[$]);
        t_req r, h;
        int k;
        k = $urandom_range(99);
        r = mk(drtt_pkg::CMD_INSERT, rand_addr(), rand_addr(),
               ($urandom_range(9) == 0) ? $urandom : $urandom_range(4096),
               rand_addr(), 2'($urandom_range(3)));
        if (k < 2) r.cmd = drtt_pkg::t_cmd'(3'd7);
        else if (k < 22) r.cmd = drtt_pkg::CMD_INSERT;
        else if (k < 40) r.cmd = drtt_pkg::CMD_MAP;
        if (k >= 40 && hist.size() != 0) begin
            h = hist[$urandom_range(hist.size() - 1)];
            if (k < 52) begin
                r.cmd = drtt_pkg::CMD_FREE; r.va = h.va;
            end else if (k < 62) begin
                r.cmd = drtt_pkg::CMD_UNMAP; r.pa = h.pa;
            end else if (k < 75) begin
                r.cmd = drtt_pkg::CMD_V2P;
                r.va = (h.cmd == drtt_pkg::CMD_MAP ? h.ca : h.va)
                       + AW'($urandom_range(h.len + 1));
            end else if (k < 88) begin
                r.cmd = drtt_pkg::CMD_P2V;
                r.pa = h.pa + AW'($urandom_range(h.len + 1));
            end else begin
                r.cmd = drtt_pkg::CMD_QUERY;
                r.va = (h.cmd == drtt_pkg::CMD_MAP ? h.ca : h.va)
                       + AW'($urandom_range(h.len + 1));
            end
        end else if (k >= 40) begin
            r.cmd = drtt_pkg::t_cmd'($urandom_range(1, 6));
        end
        if (r.cmd == drtt_pkg::CMD_INSERT || r.cmd == drtt_pkg::CMD_MAP) begin
            hist.push_back(r);
            if (hist.size() > 80) void'(hist.pop_front());
        end
        pending_cmds.push_back(r);
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    initial begin
        t_req hist[$];
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_map[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every command, zero keys, bad directions, edge spans.
        pending_cmds.push_back(mk(drtt_pkg::CMD_V2P, 48'h1000, 0, 0, 0, 0));  // empty table miss
        pending_cmds.push_back(mk(drtt_pkg::CMD_INSERT, 0, 48'h5000, 16, 0, 0)); // zero virt
        pending_cmds.push_back(mk(drtt_pkg::CMD_INSERT, 48'h1000, 0, 16, 0, 0)); // zero phys
        pending_cmds.push_back(mk(drtt_pkg::CMD_INSERT, 48'hFFFF_FFFF_FFF0, 48'hFFFF_FFFF_FFFF,
                                  32'hFFFF_FFFF, 0, 3));
        pending_cmds.push_back(mk(drtt_pkg::CMD_INSERT, 48'h2000, 48'h9000, 0, 0, 0)); // empty
        pending_cmds.push_back(mk(drtt_pkg::CMD_MAP, 48'h3000, 48'hA000, 32'h100, 48'h7000,
                                  drtt_pkg::DIR_BIDIR));
        pending_cmds.push_back(mk(drtt_pkg::CMD_MAP, 48'h3000, 48'hA000, 32'h100, 48'h7000,
                                  drtt_pkg::DIR_NONE));
        pending_cmds.push_back(mk(drtt_pkg::CMD_MAP, 48'h3000, 48'hA000, 32'h100, 48'h0,
                                  drtt_pkg::DIR_TO_DEV));
        pending_cmds.push_back(mk(drtt_pkg::CMD_MAP, 48'h3000, 48'hB000, 32'h100, 48'h7000,
                                  drtt_pkg::DIR_FROM_DEV));
        pending_cmds.push_back(mk(drtt_pkg::CMD_V2P, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0));
        pending_cmds.push_back(mk(drtt_pkg::CMD_P2V, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0));
        pending_cmds.push_back(mk(drtt_pkg::CMD_V2P, 48'h2000, 0, 0, 0, 0)); // zero-length miss
        pending_cmds.push_back(mk(drtt_pkg::CMD_QUERY, 48'h70FF, 0, 0, 0, 0));
        pending_cmds.push_back(mk(drtt_pkg::CMD_QUERY, 48'h7100, 0, 0, 0, 0));
        pending_cmds.push_back(mk(drtt_pkg::CMD_UNMAP, 0, 48'h9000, 0, 0, 0)); // plain entry
        pending_cmds.push_back(mk(drtt_pkg::CMD_UNMAP, 0, 48'hA000, 0, 0, 0));
        pending_cmds.push_back(mk(drtt_pkg::CMD_FREE, 48'h3000, 0, 0, 0, 0)); // duplicate key
        pending_cmds.push_back(mk(drtt_pkg::CMD_FREE, 48'h3000, 0, 0, 0, 0));
        pending_cmds.push_back(mk(drtt_pkg::t_cmd'(3'd7), 48'h1, 48'h1, 1, 1, 0));
        // Fill past capacity to see the table-full report, then empty it again.
        for (int i = 0; i < 66; i++)
            pending_cmds.push_back(mk(drtt_pkg::CMD_INSERT, 48'h10_0000 + i * 64,
                                      48'h20_0000 + i * 64, 64, 0, 0));
        drain();
        for (int i = 0; i < 66; i++)
            pending_cmds.push_back(mk(drtt_pkg::CMD_FREE, 48'h10_0000 + i * 64, 0, 0, 0, 0));
        pending_cmds.push_back(mk(drtt_pkg::CMD_FREE, 48'hFFFF_FFFF_FFF0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(drtt_pkg::CMD_FREE, 48'h2000, 0, 0, 0, 0));
        drain();

        // Random phases with the three idling profiles.
        send_idle_pct = 18; recv_idle_pct = 73;
        for (int i = 0; i < 600; i++) push_random(hist);
        hold_off = 400;     // long receiver hold-off while commands keep coming
        drain();
        send_idle_pct = 73; recv_idle_pct = 18;
        for (int i = 0; i < 600; i++) push_random(hist);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 620; i++) push_random(hist);
        feed_done = 1;
    end

    initial begin
        wait (feed_done);
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d commands over all seven codes plus an unused one; %0d results",
                 n_sent, n_checked);
        $display("checked, %0d with ok status, including full, zero-key and bad-direction cases.",
                 n_ok);
        if (errors == 0)
            $display("** dma_region_translation_table_top: PASSED **");
        else
            $display("** dma_region_translation_table_top: FAILED **");
        $finish;
    end

    // Timeout for the worst case: about 2000 commands under heavy stalls.
    initial begin
        #20ms;
        $display("** dma_region_translation_table_top: FAILED **");
        $finish;
    end
endmodule
